@@ rtl/sllr_pkg.sv @@
// Shared types and constants of the sensor loop level debounce reporter.
`default_nettype none
package sllr_pkg;

  localparam int SAMPLE_W = 12;
  localparam int RATIO_W  = 16;
  localparam int PERIOD_W = 10;
  localparam int LEVEL_W  = 3;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W   = SAMPLE_W + RATIO_W;

  localparam logic [LEVEL_W-1:0] LVL_0V  = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_4V  = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_8V  = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_12V = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_BAD = 3'd4;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_ALARM  = 2'd1;
  localparam logic [1:0] MODE_CNT_NO = 2'd2;
  localparam logic [1:0] MODE_CNT_NC = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET  = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd600;
  localparam logic [RATIO_W-1:0]  UPPER_RST  = 16'd54395;
  localparam logic [RATIO_W-1:0]  MIDDLE_RST = 16'd33915;
  localparam logic [RATIO_W-1:0]  LOWER_RST  = 16'd12288;
  localparam logic [LEVEL_W-1:0]  QUIET_RST  = 3'd3;
  localparam logic [PERIOD_W-1:0] SCAN_MAX   = 10'd1023;

  typedef struct packed {
    logic [3:0]          channel;
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] reference;
  } in_word_t;

  typedef struct packed {
    logic               report_kind;
    logic [3:0]         report_channel;
    logic               alarm_bit;
    logic [COUNT_W-1:0] transition_count;
  } out_word_t;

endpackage
`default_nettype wire

@@ rtl/sllr_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module sllr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sllr_class.sv @@
// Level classifier: registered ratio products, then band compares.
`default_nettype none
module sllr_class (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [sllr_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [sllr_pkg::SAMPLE_W-1:0] reference,
  input  wire logic [sllr_pkg::RATIO_W-1:0]  upper_ratio,
  input  wire logic [sllr_pkg::RATIO_W-1:0]  middle_ratio,
  input  wire logic [sllr_pkg::RATIO_W-1:0]  lower_ratio,
  output logic      [sllr_pkg::LEVEL_W-1:0]  level
);
  import sllr_pkg::*;

  logic [PROD_W-1:0]   up_r, mid_r, low_r;
  logic [SAMPLE_W-1:0] smp_r, ref_r;
  logic [PROD_W-1:0]   sv;

  always_ff @(posedge clk) begin
    if (en) begin
      up_r  <= PROD_W'(upper_ratio) * PROD_W'(reference);
      mid_r <= PROD_W'(middle_ratio) * PROD_W'(reference);
      low_r <= PROD_W'(lower_ratio) * PROD_W'(reference);
      smp_r <= sample;
      ref_r <= reference;
    end
  end

  assign sv = {smp_r, {RATIO_W{1'b0}}};

  // bands tested in order, as a chain; a sample above the reference falls through to invalid
  always_comb begin
    if (smp_r <= ref_r && sv > up_r) begin
      level = LVL_12V;
    end else if (sv <= up_r && sv > mid_r) begin
      level = LVL_8V;
    end else if (sv <= mid_r && sv > low_r) begin
      level = LVL_4V;
    end else if (sv <= low_r) begin
      level = LVL_0V;
    end else begin
      level = LVL_BAD;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sllr_update.sv @@
// Per-channel state update: debounce, report decision, tally and scan count.
`default_nettype none
module sllr_update #(
  parameter int TALLY_BITS = 16
) (
  input  wire logic [3:0]                    channel,
  input  wire logic [1:0]                    mode,
  input  wire logic [sllr_pkg::LEVEL_W-1:0]  cur,
  input  wire logic [sllr_pkg::PERIOD_W-1:0] publish_period,
  input  wire logic [sllr_pkg::LEVEL_W-1:0]  quiet_level,
  input  wire logic [sllr_pkg::LEVEL_W-1:0]  last_raw,
  input  wire logic [sllr_pkg::LEVEL_W-1:0]  stable,
  input  wire logic [sllr_pkg::PERIOD_W-1:0] scans,
  input  wire logic [TALLY_BITS-1:0]         tally,
  output logic      [sllr_pkg::LEVEL_W-1:0]  last_raw_nxt,
  output logic      [sllr_pkg::LEVEL_W-1:0]  stable_nxt,
  output logic      [sllr_pkg::PERIOD_W-1:0] scans_nxt,
  output logic      [TALLY_BITS-1:0]         tally_nxt,
  output logic                               report,
  output sllr_pkg::out_word_t                res
);
  import sllr_pkg::*;

  logic                   due, cb, pb, prev_hi, prev_lo, now_hi, now_lo, edge_hit;
  logic [LEVEL_W-1:0]     now_lvl;
  logic [TALLY_BITS-1:0]  tally_inc;
  logic [TALLY_BITS+COUNT_W-1:0] tally_ext;
  logic [PERIOD_W-1:0]    scans_base;

  always_comb begin
    now_lvl  = (cur == last_raw) ? cur : stable;
    due      = scans >= publish_period;
    cb       = now_lvl != quiet_level;
    pb       = stable != quiet_level;
    prev_hi  = stable == LVL_12V || stable == LVL_8V;
    prev_lo  = stable == LVL_0V || stable == LVL_4V;
    now_hi   = now_lvl == LVL_12V || now_lvl == LVL_8V;
    now_lo   = now_lvl == LVL_0V || now_lvl == LVL_4V;
    edge_hit = 1'b0;
    report   = 1'b0;
    res      = '0;
    res.report_channel = channel;

    case (mode)
      MODE_ALARM: begin
        report        = (cb != pb) || due;
        res.alarm_bit = cb;
      end
      MODE_CNT_NO, MODE_CNT_NC: begin
        edge_hit        = (mode == MODE_CNT_NO) ? (prev_hi && now_lo) : (prev_lo && now_hi);
        report          = due;
        res.report_kind = 1'b1;
      end
      default: begin
        report = 1'b0;
      end
    endcase

    tally_inc = edge_hit ? tally + TALLY_BITS'(1) : tally;
    tally_ext = {{COUNT_W{1'b0}}, tally_inc};
    if (res.report_kind) begin
      res.transition_count = tally_ext[COUNT_W-1:0];
    end
    tally_nxt = (res.report_kind && report) ? '0 : tally_inc;

    scans_base   = report ? '0 : scans;
    scans_nxt    = (scans_base == SCAN_MAX) ? scans_base : scans_base + PERIOD_W'(1);
    last_raw_nxt = cur;
    stable_nxt   = now_lvl;
  end

endmodule
`default_nettype wire

@@ rtl/sensor_loop_level_debounce_reporter_core.sv @@
// Sensor loop level debounce reporter: top level with state RAM and pipeline.
//
// One word is taken per clock cycle while the output is not stalled; any report
// it causes goes from stage 2 into the output register. Per-channel state (last raw
// level, debounced level, scan count, transition tally) sits in one state RAM
// that is read from the first stage and written back at the end of the second;
// one write-back forwarding register covers back-to-back words of the same
// channel, which sets the one-word-per-cycle figure. Per-entry valid bits make
// every channel read as freshly reset (invalid levels, zero counts) until
// written, so no clearing pass follows reset. Channel numbers at or above
// CHANNELS are dropped. A stalled output holds the whole pipeline and in_stall
// follows it.
`default_nettype none
module sensor_loop_level_debounce_reporter_core #(
  parameter int CHANNELS   = 15,
  parameter int TALLY_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sllr_pkg::in_word_t              in_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output sllr_pkg::out_word_t                  out_word,
  input  wire logic                            cfg_we,
  input  wire logic [sllr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sllr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sllr_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = 2 * LEVEL_W + PERIOD_W + TALLY_BITS;

  // configuration registers
  logic [PERIOD_W-1:0] period_r;
  logic [RATIO_W-1:0]  upper_r, middle_r, lower_r;
  logic [LEVEL_W-1:0]  quiet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      upper_r  <= UPPER_RST;
      middle_r <= MIDDLE_RST;
      lower_r  <= LOWER_RST;
      quiet_r  <= QUIET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        CFG_UPPER:  upper_r  <= cfg_data[RATIO_W-1:0];
        CFG_MIDDLE: middle_r <= cfg_data[RATIO_W-1:0];
        CFG_LOWER:  lower_r  <= cfg_data[RATIO_W-1:0];
        CFG_QUIET:  quiet_r  <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: captured word, RAM read issued
  logic      v1_r;
  in_word_t  w1_r;
  logic [AW+3:0] ch1_ext;
  logic [AW-1:0] addr1;
  logic          rng1;

  assign ch1_ext = {{AW{1'b0}}, w1_r.channel};
  assign addr1   = ch1_ext[AW-1:0];
  assign rng1    = 32'(w1_r.channel) < 32'(CHANNELS);

  // stage 2: classify, modify, write back
  logic          v2_r, rng2_r, rvld2_r;
  logic [3:0]    ch2_r;
  logic [1:0]    mode2_r;
  logic [AW-1:0] addr2_r;

  logic [CHANNELS-1:0] ent_vld_r;
  logic          wb_v_r;
  logic [AW-1:0] wb_addr_r;
  logic [EW-1:0] wb_data_r;

  logic          we;
  logic [EW-1:0] ram_q, ent, wdata;
  logic [LEVEL_W-1:0] cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      wb_v_r    <= 1'b0;
      ent_vld_r <= '0;
    end else if (adv) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      wb_v_r <= we;
      if (we) begin
        ent_vld_r[addr2_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r      <= in_word;
      ch2_r     <= w1_r.channel;
      mode2_r   <= w1_r.mode;
      addr2_r   <= addr1;
      rng2_r    <= rng1;
      rvld2_r   <= rng1 ? ent_vld_r[addr1] : 1'b0;
      wb_addr_r <= addr2_r;
      wb_data_r <= wdata;
    end
  end

  sllr_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr2_r),
    .wdata (wdata),
    .re    (adv),
    .raddr (addr1),
    .rdata (ram_q)
  );

  sllr_class u_class (
    .clk          (clk),
    .en           (adv),
    .sample       (w1_r.sample),
    .reference    (w1_r.reference),
    .upper_ratio  (upper_r),
    .middle_ratio (middle_r),
    .lower_ratio  (lower_r),
    .level        (cur)
  );

  // the RAM reads old data when the previous word wrote the same entry
  always_comb begin
    if (wb_v_r && wb_addr_r == addr2_r) begin
      ent = wb_data_r;
    end else if (rvld2_r) begin
      ent = ram_q;
    end else begin
      ent = {LVL_BAD, LVL_BAD, {(PERIOD_W + TALLY_BITS){1'b0}}};
    end
  end

  logic [LEVEL_W-1:0]    last_nxt, stable_nxt;
  logic [PERIOD_W-1:0]   scans_nxt;
  logic [TALLY_BITS-1:0] tally_nxt;
  logic                  report;
  out_word_t             res;

  sllr_update #(
    .TALLY_BITS (TALLY_BITS)
  ) u_update (
    .channel        (ch2_r),
    .mode           (mode2_r),
    .cur            (cur),
    .publish_period (period_r),
    .quiet_level    (quiet_r),
    .last_raw       (ent[EW-1 -: LEVEL_W]),
    .stable         (ent[EW-LEVEL_W-1 -: LEVEL_W]),
    .scans          (ent[TALLY_BITS+PERIOD_W-1 -: PERIOD_W]),
    .tally          (ent[TALLY_BITS-1:0]),
    .last_raw_nxt   (last_nxt),
    .stable_nxt     (stable_nxt),
    .scans_nxt      (scans_nxt),
    .tally_nxt      (tally_nxt),
    .report         (report),
    .res            (res)
  );

  assign wdata = {last_nxt, stable_nxt, scans_nxt, tally_nxt};
  assign we    = adv && v2_r && rng2_r;

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r && rng2_r && report;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
